@@ sv/masp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step generator package
// Shared types, opcodes and constants of the multi-axis step generator.
// ----------------------------------------------------------------------------
package masp_pkg;

  localparam int AXES      = 3;
  localparam int FRAC_BITS = 30;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] ONE_STEP = 32'(1) << FRAC_BITS;

  // opcodes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_LOAD_TIME = 3'd1;
  localparam logic [2:0] OP_LOAD_AXIS = 3'd2;
  localparam logic [2:0] OP_START     = 3'd3;
  localparam logic [2:0] OP_PULSE_END = 3'd4;
  localparam logic [2:0] OP_HALT      = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INV = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_INV  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         axis_index;
    logic               axis_direction;
    logic [31:0]        step_total;
    logic [30:0]        start_rate;
    logic signed [31:0] accel_change;
    logic signed [31:0] decel_change;
    logic [30:0]        cruise_rate;
    logic [31:0]        first_event_tick;
    logic [31:0]        accel_end;
    logic [31:0]        decel_start;
    logic [31:0]        total_ticks;
  } in_item_t;

  typedef struct packed {
    logic [AXES-1:0] step_level;
    logic [AXES-1:0] dir_level;
    logic [AXES-1:0] stepped_axes;
    logic            busy_res;
    logic            move_done;
    logic            block_empty;
  } res_item_t;

  // per-cell commands from the sequencer
  typedef struct packed {
    logic tick_en;
    logic load_en;
    logic start_go;
    logic clear_moving;
  } cell_ctrl_t;

  // block timing and current tick, broadcast to every cell
  typedef struct packed {
    logic [31:0] tick_count;
    logic [31:0] acc_until;
    logic [31:0] dec_after;
    logic [31:0] total;
  } timing_t;

  // accumulated along the row of cells
  typedef struct packed {
    logic active_any;
    logic still;
  } chain_t;

  typedef struct packed {
    logic active;
    logic dir;
    logic moving;
    logic stepped;
  } cell_stat_t;

endpackage

@@ sv/masp_item_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface masp_item_if;
  import masp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/masp_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface masp_res_if;
  import masp_pkg::*;

  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/masp_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface masp_cfg_if;
  import masp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [AXES-1:0]      wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ sv/masp_axis_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis cell
// Holds one axis's profile and phase state; runs one tick of its schedule.
// ----------------------------------------------------------------------------
module masp_axis_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  masp_pkg::cell_ctrl_t ctrl_i,
  input  masp_pkg::timing_t    timing_i,
  input  masp_pkg::in_item_t   item_i,
  input  masp_pkg::chain_t     chain_i,
  output masp_pkg::chain_t     chain_o,
  output masp_pkg::cell_stat_t stat_o
);
  import masp_pkg::*;

  logic [31:0] steps_left_q, count_q, phase_q;
  logic        dir_q, moving_q;
  logic [31:0] rate_q, accel_q, decel_q, plateau_q, next_ev_q;

  logic        active, tick_live;
  logic [31:0] rate_sum, rate_sched, accel_sched, next_sched;
  logic [31:0] rate_eff, phase_base, phase_sum, count_inc;
  logic        stall, step_due, retire, still_c;

  assign active    = (steps_left_q != 32'd0);
  assign tick_live = ctrl_i.tick_en && active;

  // rate schedule
  always_comb begin
    rate_sum    = rate_q + accel_q;
    rate_sched  = rate_sum;
    accel_sched = accel_q;
    next_sched  = next_ev_q;
    if (timing_i.tick_count == next_ev_q) begin
      if (timing_i.tick_count == timing_i.acc_until) begin
        accel_sched = '0;
        if (timing_i.dec_after < timing_i.total) begin
          next_sched = timing_i.dec_after;
          if (timing_i.tick_count != timing_i.dec_after) begin
            rate_sched = plateau_q;
          end
        end
      end
      if (timing_i.tick_count == timing_i.dec_after) begin
        accel_sched = decel_q;
      end
    end
  end

  // non-positive rate forces a step
  assign stall      = (rate_sched == 32'd0) || rate_sched[31];
  assign rate_eff   = stall ? 32'd0 : rate_sched;
  assign phase_base = stall ? ONE_STEP : phase_q;
  assign phase_sum  = phase_base + rate_eff;
  assign step_due   = (phase_sum >= ONE_STEP);
  assign count_inc  = count_q + 32'd1;
  assign retire     = step_due && (!moving_q || (count_inc == steps_left_q));
  assign still_c    = tick_live && moving_q && !retire;

  assign chain_o.active_any = chain_i.active_any | active;
  assign chain_o.still      = chain_i.still | still_c;

  assign stat_o.active  = active;
  assign stat_o.dir     = dir_q;
  assign stat_o.moving  = moving_q;
  assign stat_o.stepped = tick_live && step_due && moving_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_left_q <= '0;
      count_q      <= '0;
      phase_q      <= '0;
      dir_q        <= 1'b0;
      moving_q     <= 1'b0;
    end else begin
      if (ctrl_i.load_en) begin
        dir_q        <= item_i.axis_direction;
        steps_left_q <= item_i.step_total;
        count_q      <= '0;
        phase_q      <= '0;
      end else if (tick_live) begin
        phase_q <= step_due ? (phase_sum - ONE_STEP) : phase_sum;
        if (step_due) begin
          count_q <= count_inc;
        end
        if (retire) begin
          steps_left_q <= '0;
        end
      end
      if (ctrl_i.clear_moving) begin
        moving_q <= 1'b0;
      end else if (ctrl_i.start_go) begin
        moving_q <= active;
      end else if (tick_live && retire) begin
        moving_q <= 1'b0;
      end
    end
  end

  // profile registers: undefined until loaded
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en) begin
      rate_q    <= {1'b0, item_i.start_rate};
      accel_q   <= item_i.accel_change;
      decel_q   <= item_i.decel_change;
      plateau_q <= {1'b0, item_i.cruise_rate};
      next_ev_q <= item_i.first_event_tick;
    end else if (tick_live) begin
      rate_q    <= rate_eff;
      accel_q   <= accel_sched;
      next_ev_q <= next_sched;
    end
  end

endmodule

@@ sv/multi_axis_step_pulse_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-axis step pulse generator
// Trapezoidal step generator for AXES axes built as a row of axis cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : command items (tick, load block timing, load axis, start block,
//            pulse end, halt). One transfer is one command.
//   res_o  : exactly one result transfer per command: step and direction
//            levels after inversion, axes stepped, busy, finished and empty.
//   cfg_i  : register writes (index 0 step inversion, 1 direction inversion),
//            always ready; write only while the block is idle.
// Each result is registered, in the result register or the skid entry.
// One command is taken per cycle while in_i.ready is high; the whole
// tick of every axis is worked out in that cycle by the cell row, whose
// per-axis rate add, phase add and compare set the clock period.
// A result register and one skid entry sit on the output, so a command is
// still taken while one result waits; in_i.ready falls only when both are
// full and rises again the cycle after res_o drains one.
// Reset clears the flags, masks, step counts, phases and register values;
// profile rates, increments and block timing are undefined until loaded.
// ----------------------------------------------------------------------------
module multi_axis_step_pulse_generator (
  input  logic     clk_i,
  input  logic     rst_ni,
  masp_item_if.sink   in_i,
  masp_res_if.source  res_o,
  masp_cfg_if.sink    cfg_i
);
  import masp_pkg::*;

  // global block state
  logic [31:0]     tick_cnt_q, tick_cnt_d;
  logic            running_q, running_d;
  logic [AXES-1:0] pulse_q, pulse_d;
  logic [AXES-1:0] dir_q, dir_d;
  logic [AXES-1:0] step_inv_q, dir_inv_q;
  logic [31:0]     acc_until_q, dec_after_q, total_q;

  // output register and skid entry
  logic      out_valid_q, skid_valid_q;
  res_item_t out_q, skid_q;

  logic            in_fire, out_fire;
  logic [2:0]      op;
  logic            tick_en, start_try, start_go, halt, finish, empty;
  logic [AXES-1:0] stepped_vec, active_vec, cdir_vec, moving_vec;
  res_item_t       res_d;
  timing_t         timing;
  chain_t          chain [AXES+1];
  cell_stat_t      stat  [AXES];

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && res_o.ready;
  assign op       = in_i.data.opcode;

  // a command is taken unless a result already waits in the skid entry
  assign in_i.ready  = !skid_valid_q;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;
  assign cfg_i.ready = 1'b1;

  // command decode
  assign tick_en   = in_fire && (op == OP_TICK) && running_q;
  assign start_try = in_fire && (op == OP_START) && !running_q;
  assign start_go  = start_try && chain[AXES].active_any;
  assign empty     = start_try && !chain[AXES].active_any;
  assign halt      = in_fire && (op == OP_HALT);
  // block ends when no active axis is still moving after this tick
  assign finish    = tick_en && !chain[AXES].still;

  assign timing.tick_count = tick_cnt_q;
  assign timing.acc_until  = acc_until_q;
  assign timing.dec_after  = dec_after_q;
  assign timing.total      = total_q;

  // row of axis cells; activity and motion accumulate along the row
  assign chain[0] = '0;

  for (genvar g = 0; g < AXES; g++) begin : g_cell
    cell_ctrl_t ctrl;

    assign ctrl.tick_en      = tick_en;
    assign ctrl.load_en      = in_fire && (op == OP_LOAD_AXIS) &&
                               (32'(in_i.data.axis_index) == g);
    assign ctrl.start_go     = start_go;
    assign ctrl.clear_moving = halt || finish;

    masp_axis_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .timing_i (timing),
      .item_i   (in_i.data),
      .chain_i  (chain[g]),
      .chain_o  (chain[g+1]),
      .stat_o   (stat[g])
    );

    assign stepped_vec[g] = stat[g].stepped;
    assign active_vec[g]  = stat[g].active;
    assign cdir_vec[g]    = stat[g].dir;
    assign moving_vec[g]  = stat[g].moving;
  end

  // next global state
  always_comb begin
    running_d  = running_q;
    tick_cnt_d = tick_cnt_q;
    pulse_d    = pulse_q;
    dir_d      = dir_q;
    if (tick_en) begin
      tick_cnt_d = finish ? 32'd0 : tick_cnt_q + 32'd1;
      if (stepped_vec != '0) begin
        pulse_d = stepped_vec;
      end
      if (finish) begin
        running_d = 1'b0;
      end
    end
    if (start_try) begin
      tick_cnt_d = '0;
    end
    if (start_go) begin
      running_d = 1'b1;
      dir_d     = active_vec & cdir_vec;
    end
    if (in_fire && (op == OP_PULSE_END)) begin
      pulse_d = '0;
    end
    if (halt) begin
      running_d  = 1'b0;
      tick_cnt_d = '0;
    end
  end

  // result of the command taken this cycle
  always_comb begin
    res_d.step_level   = pulse_d ^ step_inv_q;
    res_d.dir_level    = dir_d ^ dir_inv_q;
    res_d.stepped_axes = tick_en ? stepped_vec : '0;
    res_d.busy_res     = running_d;
    res_d.move_done    = finish;
    res_d.block_empty  = empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt_q   <= '0;
      running_q    <= 1'b0;
      pulse_q      <= '0;
      dir_q        <= '0;
      step_inv_q   <= '0;
      dir_inv_q    <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      tick_cnt_q <= tick_cnt_d;
      running_q  <= running_d;
      pulse_q    <= pulse_d;
      dir_q      <= dir_d;

      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_STEP_INV: step_inv_q <= cfg_i.wdata;
          CFG_DIR_INV:  dir_inv_q  <= cfg_i.wdata;
          default: ;
        endcase
      end

      // result register with one skid entry
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid_q && !out_fire) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && (op == OP_LOAD_TIME)) begin
      acc_until_q <= in_i.data.accel_end;
      dec_after_q <= in_i.data.decel_start;
      total_q     <= in_i.data.total_ticks;
    end
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // skid entry only ever backs up a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  // an idle block has no moving axes
  a_idle_not_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (moving_vec == '0))
    else $error("axis moving while no block runs");

  // only moving axes issue steps
  a_step_needs_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_en |-> ((stepped_vec & ~moving_vec) == '0))
    else $error("step issued on an axis that is not moving");

  // a finished block restarts its tick count
  a_finish_clears_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (tick_cnt_q == 32'd0) && !running_q)
    else $error("tick count or busy not cleared at block end");
`endif

endmodule
